FILE: rtl/core/rde_pkg.sv
`default_nettype none

package rde_pkg;

	localparam int VALUE_BITS = 31;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 7;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;
	localparam int REG_IDX_W  = ADDR_W - 2;

	localparam int STEP_BITS  = 4;
	localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int DIV_W      = DIV_CYCLES * STEP_BITS;
	localparam int STEP_CNT_W = $clog2(DIV_CYCLES);
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int IDX_W      = $clog2(VALUE_BITS);

	localparam int CQ_DEPTH   = 2;
	localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);

	localparam logic [REG_IDX_W-1:0] REG_RADIX = '0;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'd48;
	localparam logic [CHAR_W-1:0]  ASCII_UPPER_A = 7'd65;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_W-1:0]    radix;
	} cmd_t;

	typedef struct packed {
		logic pop;
	} cq_rd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_EMIT
	} back_state_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ch;
		if (d < DECIMAL_LIMIT) begin
			ch = ASCII_ZERO + CHAR_W'(d);
		end else begin
			ch = ASCII_UPPER_A + CHAR_W'(d - DECIMAL_LIMIT);
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rde_front.sv
`default_nettype none

module rde_front
	import rde_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_W-1:0]     paddr,
	input  wire logic [DATA_W-1:0]     pwdata,
	output logic      [DATA_W-1:0]     prdata,
	input  wire logic                  push,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic                  cq_full,
	output logic                       cq_push,
	output cmd_t                       cq_cmd
);

	logic [RADIX_W-1:0]   radix_q;
	logic [RADIX_W-1:0]   radix_eff;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & (reg_idx == REG_RADIX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (wr_en) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_RADIX) begin
			prdata = DATA_W'(radix_q);
		end
	end

	// clamp to the supported bases
	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			radix_eff = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			radix_eff = RADIX_MAX;
		end else begin
			radix_eff = radix_q;
		end
	end

	assign cq_push      = push & ~cq_full;
	assign cq_cmd.value = value;
	assign cq_cmd.radix = radix_eff;

endmodule

`default_nettype wire

FILE: rtl/core/rde_cmd_fifo.sv
`default_nettype none

module rde_cmd_fifo
	import rde_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic rd_pop,
	output logic      rd_valid,
	output cmd_t      rd_cmd
);

	cmd_t                mem_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full     = (count_q == CQ_CNT_W'(CQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_push  = push & ~full;
	assign do_pop   = rd_pop & rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/rde_back.sv
`default_nettype none

module rde_back
	import rde_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output cq_rd_t                  cq,
	input  wire logic               cmd_valid,
	input  wire logic               pop,
	output logic                    empty,
	output logic      [CHAR_W-1:0]  digit_char,
	output logic                    last
);

	back_state_t           state_q;
	back_state_t           state_d;
	logic [DIV_W-1:0]      work_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [RADIX_W-1:0]    radix_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIGIT_W-1:0]    stack_q [VALUE_BITS];
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     out_char_q;
	logic                  out_last_q;

	logic                  start;
	logic                  div_en;
	logic                  div_last;
	logic                  emit_load;
	logic                  div_finish;
	logic [DIV_W-1:0]      work_d;
	logic [DIGIT_W-1:0]    rem_d;
	logic [RADIX_W:0]      trial;
	logic [CNT_W-1:0]      cnt_inc;
	logic [IDX_W-1:0]      top_idx;

	// restoring division, STEP_BITS quotient bits per cycle
	always_comb begin
		work_d = work_q;
		rem_d  = rem_q;
		trial  = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial  = {1'b0, rem_d, work_d[DIV_W-1]};
			work_d = {work_d[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, radix_q}) begin
				trial     = trial - {1'b0, radix_q};
				work_d[0] = 1'b1;
			end
			rem_d = trial[DIGIT_W-1:0];
		end
	end

	assign div_last   = (step_q == STEP_CNT_W'(DIV_CYCLES - 1));
	assign cnt_inc    = cnt_q + 1'b1;
	assign div_finish = (work_d == '0) || (cnt_inc == CNT_W'(VALUE_BITS));
	assign top_idx    = IDX_W'(cnt_q - 1'b1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (div_last && div_finish) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				if (emit_load && (cnt_q == CNT_W'(1))) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		start     = 1'b0;
		div_en    = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			B_IDLE:  start     = cmd_valid;
			B_DIV:   div_en    = 1'b1;
			B_EMIT:  emit_load = ~out_valid_q | pop;
			default: start     = 1'b0;
		endcase
	end

	assign cq.pop = start;

	always_ff @(posedge clk) begin
		if (start) begin
			work_q  <= DIV_W'(cmd.value);
			rem_q   <= '0;
			radix_q <= cmd.radix;
		end else if (div_en) begin
			if (div_last) begin
				stack_q[cnt_q[IDX_W-1:0]] <= rem_d;
				rem_q                     <= '0;
			end else begin
				rem_q <= rem_d;
			end
			work_q <= work_d;
		end
		if (emit_load) begin
			out_char_q <= digit_to_ascii(stack_q[top_idx]);
			out_last_q <= (cnt_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				step_q <= '0;
				cnt_q  <= '0;
			end else if (div_en) begin
				step_q <= div_last ? '0 : step_q + 1'b1;
				if (div_last) begin
					cnt_q <= cnt_inc;
				end
			end else if (emit_load) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty      = ~out_valid_q;
	assign digit_char = out_char_q;
	assign last       = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/radix_digit_emitter.sv
// channel   dir  transfer when        payload
// config    in   psel&penable&pwrite  pwdata -> radix (paddr 0)
// value     in   push & !full         value
// digit     out  pop & !empty         digit_char, last
//
// The divider yields an item's digits one at a time (four quotient bits a cycle);
// they are then emitted most significant first, one digit a cycle while pop is held.
// Reset clears the control state and sets radix to 10; no clearing pass follows.
// A two-entry command queue lets new values be taken while the divider is busy;
// the output register lets the next conversion start while a digit waits.
`default_nettype none

module radix_digit_emitter
	import rde_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_W-1:0]     paddr,
	input  wire logic [DATA_W-1:0]     pwdata,
	output logic      [DATA_W-1:0]     prdata,
	output logic                       pready,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       empty,
	input  wire logic                  pop,
	output logic      [CHAR_W-1:0]     digit_char,
	output logic                       last
);

	cmd_t   fe_cmd;
	cmd_t   be_cmd;
	logic   fe_push;
	logic   cq_full;
	logic   cq_valid;
	cq_rd_t cq_rd;

	assign pready = 1'b1;
	assign full   = cq_full;

	rde_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.push    (push),
		.value   (value),
		.cq_full (cq_full),
		.cq_push (fe_push),
		.cq_cmd  (fe_cmd)
	);

	rde_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fe_push),
		.push_cmd (fe_cmd),
		.full     (cq_full),
		.rd_pop   (cq_rd.pop),
		.rd_valid (cq_valid),
		.rd_cmd   (be_cmd)
	);

	rde_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (be_cmd),
		.cq         (cq_rd),
		.cmd_valid  (cq_valid),
		.pop        (pop),
		.empty      (empty),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

`default_nettype wire

FILE: rtl/core/rde_checker.sv
`default_nettype none

module rde_checker
	import rde_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  psel,
	input wire logic                  penable,
	input wire logic                  pwrite,
	input wire logic [ADDR_W-1:0]     paddr,
	input wire logic [DATA_W-1:0]     pwdata,
	input wire logic [DATA_W-1:0]     prdata,
	input wire logic                  pready,
	input wire logic                  empty,
	input wire logic                  pop,
	input wire logic [CHAR_W-1:0]     digit_char,
	input wire logic                  last
);

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(digit_char) && $stable(last)))
		else $error("waiting digit changed before transfer");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((digit_char >= 7'd48 && digit_char <= 7'd57)
			|| (digit_char >= 7'd65 && digit_char <= 7'd70)))
		else $error("digit outside 0-9, A-F");

	a_radix_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_RADIX)
			##1 (psel && !pwrite && paddr[ADDR_W-1:2] == REG_RADIX)
			|-> (prdata == DATA_W'($past(pwdata[RADIX_W-1:0]))))
		else $error("radix readback mismatch");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (.*);

`default_nettype wire

FILE: sim/radix_digit_emitter_tb.sv
`timescale 1ns / 1ps

module radix_digit_emitter_tb;
	import rde_pkg::*;

	localparam int PHASES         = 12;
	localparam int ITEMS_PER_PHASE = 20;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 300;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int STUCK_LIMIT    = 5000;
	localparam int LOW_BASE       = 2;
	localparam int HIGH_BASE      = 16;
	localparam int DECIMAL_DIGITS = 10;
	localparam longint VALUE_MAX  = (64'd1 << VALUE_BITS) - 1;

	localparam logic [ADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};
	localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} digit_t;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [ADDR_W-1:0]     paddr   = '0;
	logic [DATA_W-1:0]     pwdata  = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  push    = 1'b0;
	logic                  full;
	logic [VALUE_BITS-1:0] value   = '0;
	logic                  empty;
	logic                  pop     = 1'b0;
	logic [CHAR_W-1:0]     digit_char;
	logic                  last;

	logic [VALUE_BITS-1:0] value_backlog[$];
	digit_t                digit_queue[$];
	digit_t                want_digit;
	logic [RADIX_W-1:0]    radix_shadow = RADIX_W'(10);
	int                    send_idle_pct;
	int                    recv_idle_pct;
	int                    holdoff_asked;
	int                    holdoff_given;
	int                    holdoff_left;
	int                    stuck_cycles;
	int                    mismatches;
	int                    radix_plan[PHASES] = '{10, 2, 16, 0, 31, 3, 7, 13, 1, 17, 0, 0};

	radix_digit_emitter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.push       (push),
		.full       (full),
		.value      (value),
		.empty      (empty),
		.pop        (pop),
		.digit_char (digit_char),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_base();
		if (radix_shadow < LOW_BASE) return LOW_BASE;
		if (radix_shadow > HIGH_BASE) return HIGH_BASE;
		return int'(radix_shadow);
	endfunction

	function automatic void queue_digits(input logic [VALUE_BITS-1:0] v);
		int                    base;
		int                    digits[$];
		logic [VALUE_BITS-1:0] rest;
		digit_t                entry;
		base = eff_base();
		rest = v;
		do begin
			digits.push_front(int'(rest % base));
			rest = rest / base;
		end while (rest != 0);
		foreach (digits[k]) begin
			if (digits[k] < DECIMAL_DIGITS)
				entry.ch = CHAR_W'("0") + CHAR_W'(digits[k]);
			else
				entry.ch = CHAR_W'("A") + CHAR_W'(digits[k] - DECIMAL_DIGITS);
			entry.last = (k == digits.size() - 1);
			digit_queue.push_back(entry);
		end
	endfunction

	function automatic logic [VALUE_BITS-1:0] pick_value();
		longint span;
		int     steps;
		span = 1;
		case ($urandom_range(5))
			0, 1: return VALUE_BITS'($urandom);
			2: return VALUE_BITS'($urandom) >> $urandom_range(VALUE_BITS - 1, 1);
			3: return VALUE_BITS'($urandom_range(40));
			4: begin
				steps = $urandom_range(VALUE_BITS - 1, 1);
				repeat (steps) begin
					if (span * eff_base() <= VALUE_MAX) span = span * eff_base();
				end
				return VALUE_BITS'(span - $urandom_range(1));
			end
			default: return VALUE_BITS'(VALUE_MAX - $urandom_range(3));
		endcase
	endfunction

	task automatic apb_transfer(input logic wr, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d, output logic [DATA_W-1:0] rd);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_radix();
		logic [DATA_W-1:0] rd;
		apb_transfer(1'b0, RADIX_ADDR, '0, rd);
		if (rd !== DATA_W'(radix_shadow)) begin
			$display("%0t: radix read expected %0d got %0d", $time, radix_shadow, rd);
			mismatches++;
		end
		@(negedge clk);
	endtask

	task automatic set_register(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
		logic [DATA_W-1:0] rd;
		while (value_backlog.size() != 0 || digit_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_transfer(1'b1, a, d, rd);
		if (a[ADDR_W-1:2] == REG_RADIX) radix_shadow = d[RADIX_W-1:0];
		check_radix();
	endtask

	task automatic set_pace(input int regime);
		case (regime)
			0: begin send_idle_pct = 37; recv_idle_pct = 54; end
			1: begin send_idle_pct = 54; recv_idle_pct = 37; end
			default: begin send_idle_pct = 0; recv_idle_pct = 0; end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push  <= 1'b0;
			value <= '0;
		end else begin
			if (push && !full) begin
				queue_digits(value);
				void'(value_backlog.pop_front());
			end
			if (push && full) begin
				// hold until the transfer
			end else if (value_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				push  <= 1'b1;
				value <= value_backlog[0];
			end else begin
				push  <= 1'b0;
				value <= VALUE_BITS'($urandom);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (digit_queue.size() == 0) begin
					$display("%0t: digit expected none got %0d last %b", $time, digit_char, last);
					mismatches++;
				end else begin
					want_digit = digit_queue.pop_front();
					if (digit_char !== want_digit.ch) begin
						$display("%0t: digit_char expected %0d got %0d", $time,
							want_digit.ch, digit_char);
						mismatches++;
					end
					if (last !== want_digit.last) begin
						$display("%0t: last expected %b got %b", $time, want_digit.last, last);
						mismatches++;
					end
				end
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
			end else if (holdoff_given != holdoff_asked) begin
				holdoff_given++;
				holdoff_left = HOLDOFF_CYCLES;
			end
			pop <= (holdoff_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stuck_cycles <= 0;
			else if (value_backlog.size() != 0 || digit_queue.size() != 0)
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int plan;
		set_pace(0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		check_radix();

		// decimal at the reset base
		value_backlog = '{0, 1, 9, 10, 99, 100, 999999999, 1000000000, 31'h7FFF_FFFF};
		set_register(RADIX_ADDR, 32'hFFFF_FFF0);
		value_backlog = '{31'h7EDC_BA98, 31'h0123_4567, 31'hF, 31'h10};
		set_register(RADIX_ADDR, 32'd2);
		value_backlog = '{31'h7FFF_FFFF, 31'h2AAA_AAAA, 31'h5555_5555};
		// write past the register list, base must stay at two
		set_register(SPARE_ADDR, 32'd16);
		value_backlog.push_back(31'd5);
		set_register(RADIX_ADDR, 32'd0);
		value_backlog.push_back(31'd6);
		set_register(RADIX_ADDR, 32'd1);
		value_backlog.push_back(31'd6);
		set_register(RADIX_ADDR, 32'hFFFF_FFF1);
		value_backlog.push_back(31'd255);
		set_register(RADIX_ADDR, 32'd31);
		value_backlog.push_back(31'h7FFF_FFFF);

		for (int p = 0; p < PHASES; p++) begin
			plan = (p >= PHASES - 2) ? $urandom_range(31) : radix_plan[p];
			set_register(RADIX_ADDR, (DATA_W'($urandom) << RADIX_W) | DATA_W'(plan));
			set_pace(p * 3 / PHASES);
			if (p == 1 || p == 9) holdoff_asked++;
			repeat (ITEMS_PER_PHASE) value_backlog.push_back(pick_value());
		end

		while (value_backlog.size() != 0 || digit_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/rde_pkg.sv
rtl/core/rde_front.sv
rtl/core/rde_cmd_fifo.sv
rtl/core/rde_back.sv
rtl/core/radix_digit_emitter.sv
rtl/core/rde_checker.sv
sim/radix_digit_emitter_tb.sv
